>>> sv/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types and constants of the playlist controller: input kinds,
// register indexes, frame bytes and the queue entry passed to the framer.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int TRACK_W  = 12;
  localparam int MS_W     = 22;
  localparam int CMD_W    = 8;
  localparam int PAR_W    = 16;
  localparam int CFG_AW   = 1;
  localparam int FRAME_LEN = 10;
  localparam int IDX_W    = 4;

  // Input kinds carried on in_tuser.
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_RX   = 2'd1;
  localparam logic [1:0] OP_HOST = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] CFG_TRACK_COUNT = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_PERIOD_MS   = 1'd1;

  localparam logic [TRACK_W-1:0] TRACK_COUNT_RST = 12'd3;
  localparam logic [MS_W-1:0]    PERIOD_MS_RST   = 22'd30000;
  localparam logic [MS_W-1:0]    MS_MAX          = 22'h3FFFFF;

  // Frame bytes.
  localparam logic [7:0] BYTE_START   = 8'h7E;
  localparam logic [7:0] BYTE_VERSION = 8'hFF;
  localparam logic [7:0] BYTE_LEN     = 8'h06;
  localparam logic [7:0] BYTE_FEEDBK  = 8'h01;
  localparam logic [7:0] BYTE_END     = 8'hEF;
  localparam logic [7:0] CMD_PLAY     = 8'h03;
  localparam logic [7:0] REPLY_DONE   = 8'h3D;

  // Position of the command byte inside a reply.
  localparam logic [IDX_W-1:0] REPLY_KIND_POS = 4'd3;
  localparam logic [IDX_W-1:0] REPLY_LAST_POS = 4'd9;
  localparam logic [IDX_W-1:0] FRAME_LAST_IDX = 4'd9;

  // Byte positions of an outgoing frame.
  localparam logic [IDX_W-1:0] POS_START   = 4'd0;
  localparam logic [IDX_W-1:0] POS_VERSION = 4'd1;
  localparam logic [IDX_W-1:0] POS_LEN     = 4'd2;
  localparam logic [IDX_W-1:0] POS_CMD     = 4'd3;
  localparam logic [IDX_W-1:0] POS_FEEDBK  = 4'd4;
  localparam logic [IDX_W-1:0] POS_PAR_HI  = 4'd5;
  localparam logic [IDX_W-1:0] POS_PAR_LO  = 4'd6;
  localparam logic [IDX_W-1:0] POS_SUM_HI  = 4'd7;
  localparam logic [IDX_W-1:0] POS_SUM_LO  = 4'd8;
  localparam logic [IDX_W-1:0] POS_END     = 4'd9;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PAR_W-1:0]   par;
    logic [TRACK_W-1:0] track;
  } frame_req_t;

  localparam int REQ_W = $bits(frame_req_t);

endpackage

>>> sv/mpc_front.sv
// ----------------------------------------------------------------------------
// mpc_front
// Accepts input items, keeps the track timer, the reply collector and the
// configuration registers, and queues one frame request per outgoing frame.
// ----------------------------------------------------------------------------
module mpc_front
  import mpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_AW-1:0]    cfg_addr,
  input  logic [MS_W-1:0]      cfg_wdata,
  input  logic                 accept,
  input  logic [1:0]           op,
  input  logic [7:0]           rx_byte,
  input  logic [CMD_W-1:0]     command,
  input  logic [PAR_W-1:0]     parameter_req,
  output logic                 push,
  output frame_req_t           push_req
);

  logic [TRACK_W-1:0] track_count_r, track_count_nxt;
  logic [MS_W-1:0]    period_r, period_nxt;
  logic [TRACK_W-1:0] track_r, track_nxt;
  logic [MS_W-1:0]    elapsed_r, elapsed_nxt;
  logic [IDX_W-1:0]   reply_cnt_r, reply_cnt_nxt;
  logic [7:0]         reply_kind_r, reply_kind_nxt;

  logic [MS_W-1:0]    elapsed_inc;
  logic [TRACK_W-1:0] track_inc;
  logic [TRACK_W-1:0] track_adv;

  assign elapsed_inc = (elapsed_r != MS_MAX) ? elapsed_r + 1'b1 : elapsed_r;
  assign track_inc   = track_r + 1'b1;
  // Wrap to the first track past the count; a count of zero always gives 1.
  assign track_adv   = (track_inc > track_count_r || track_inc == '0) ?
                       TRACK_W'(1) : track_inc;

  always_comb begin
    track_count_nxt = track_count_r;
    period_nxt      = period_r;
    track_nxt       = track_r;
    elapsed_nxt     = elapsed_r;
    reply_cnt_nxt   = reply_cnt_r;
    reply_kind_nxt  = reply_kind_r;
    push            = 1'b0;
    push_req.cmd    = CMD_PLAY;
    push_req.par    = PAR_W'(track_adv);
    push_req.track  = track_adv;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_TRACK_COUNT: track_count_nxt = cfg_wdata[TRACK_W-1:0];
        CFG_PERIOD_MS:   period_nxt      = cfg_wdata;
        default: ;
      endcase
    end

    if (accept) begin
      case (op)
        OP_TICK: begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= period_r) begin
            track_nxt   = track_adv;
            elapsed_nxt = '0;
            push        = 1'b1;
          end
        end
        OP_RX: begin
          if (reply_cnt_r == '0) begin
            if (rx_byte == BYTE_START) reply_cnt_nxt = IDX_W'(1);
          end else if (reply_cnt_r == REPLY_LAST_POS) begin
            // The tenth byte closes the reply whatever it held.
            reply_cnt_nxt = '0;
            if (reply_kind_r == REPLY_DONE) begin
              track_nxt   = track_adv;
              elapsed_nxt = '0;
              push        = 1'b1;
            end
          end else begin
            if (reply_cnt_r == REPLY_KIND_POS) reply_kind_nxt = rx_byte;
            reply_cnt_nxt = reply_cnt_r + 1'b1;
          end
        end
        OP_HOST: begin
          push           = 1'b1;
          push_req.cmd   = command;
          push_req.par   = parameter_req;
          push_req.track = track_r;
          if (command == CMD_PLAY) elapsed_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_count_r <= TRACK_COUNT_RST;
      period_r      <= PERIOD_MS_RST;
      track_r       <= TRACK_W'(1);
      elapsed_r     <= '0;
      reply_cnt_r   <= '0;
      reply_kind_r  <= '0;
    end else begin
      track_count_r <= track_count_nxt;
      period_r      <= period_nxt;
      track_r       <= track_nxt;
      elapsed_r     <= elapsed_nxt;
      reply_cnt_r   <= reply_cnt_nxt;
      reply_kind_r  <= reply_kind_nxt;
    end
  end

endmodule

>>> sv/mpc_queue.sv
// ----------------------------------------------------------------------------
// mpc_queue
// Small first-in first-out queue of frame requests between the front and the
// framer.
// ----------------------------------------------------------------------------
module mpc_queue
  import mpc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_req_t push_req,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output frame_req_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  frame_req_t         slots_r [DEPTH];
  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/mpc_framer.sv
// ----------------------------------------------------------------------------
// mpc_framer
// Takes frame requests from the queue and sends each as ten bytes, one per
// transfer, with the checksum worked out from the held request.
// ----------------------------------------------------------------------------
module mpc_framer
  import mpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  frame_req_t         q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         tx_byte,
  output logic               frame_last,
  output logic [TRACK_W-1:0] track_number
);

  frame_req_t       req_r, req_nxt;
  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             load;
  logic [15:0]      sum;
  logic [15:0]      csum;

  assign out_valid    = busy_r;
  assign frame_last   = (idx_r == FRAME_LAST_IDX);
  assign track_number = req_r.track;

  // The next request is taken while idle, or as soon as the end byte leaves.
  assign load  = !busy_r || (out_ready && frame_last);
  assign q_pop = load && q_valid;

  assign sum  = 16'(BYTE_VERSION) + 16'(BYTE_LEN) + 16'(BYTE_FEEDBK) + 16'(req_r.cmd)
              + 16'(req_r.par[15:8]) + 16'(req_r.par[7:0]);
  assign csum = 16'(16'd0 - sum);

  always_comb begin
    case (idx_r)
      POS_START:   tx_byte = BYTE_START;
      POS_VERSION: tx_byte = BYTE_VERSION;
      POS_LEN:     tx_byte = BYTE_LEN;
      POS_CMD:     tx_byte = req_r.cmd;
      POS_FEEDBK:  tx_byte = BYTE_FEEDBK;
      POS_PAR_HI:  tx_byte = req_r.par[15:8];
      POS_PAR_LO:  tx_byte = req_r.par[7:0];
      POS_SUM_HI:  tx_byte = csum[15:8];
      POS_SUM_LO:  tx_byte = csum[7:0];
      POS_END:     tx_byte = BYTE_END;
      default:     tx_byte = BYTE_END;
    endcase
  end

  always_comb begin
    req_nxt  = req_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = q_valid;
      idx_nxt  = '0;
      if (q_valid) req_nxt = q_head;
    end else if (out_ready) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

>>> sv/mp3_module_playlist_controller_top.sv
// ----------------------------------------------------------------------------
// mp3_module_playlist_controller_top
// Playlist controller that builds command frames for a serial audio player.
//
// Input channel in_*: one item per transfer; in_tuser gives the kind
// (millisecond tick, received reply byte, host command). Output channel out_*:
// one frame byte per transfer, ten per frame, out_tlast on the end byte, and
// the frame's track number beside each byte. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata (index 0 track count, index 1 period in ms).
// The front updates the timer, track and reply collector in the cycle an item
// is transferred and queues a request when a frame must go out. The request
// is registered in the queue and then in the framer before the first byte of
// that frame can leave; frames follow each other without gaps while further
// requests are queued. Items are taken one per cycle while the request queue
// has room, so in_tready drops only while QUEUE_DEPTH frame requests wait in
// the queue. A stalled out_tready holds the current byte steady.
// Synchronous reset restores track 1, a cleared timer and collector, a track
// count of 3 and a period of 30000 ms, and empties the queue.
// ----------------------------------------------------------------------------
module mp3_module_playlist_controller_top
  import mpc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [MS_W-1:0]   cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // rx_byte, command, parameter_req
  input  logic [1:0]        in_tuser,   // op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // tx_byte, track_number, zero fill
  output logic              out_tlast   // frame_last
);

  logic               accept;
  logic               push;
  frame_req_t         push_req;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  frame_req_t         q_head;
  logic [7:0]         tx_byte;
  logic [TRACK_W-1:0] track_number;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign out_tdata = {4'd0, track_number, tx_byte};

  mpc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .accept        (accept),
    .op            (in_tuser),
    .rx_byte       (in_tdata[7:0]),
    .command       (in_tdata[15:8]),
    .parameter_req (in_tdata[31:16]),
    .push          (push),
    .push_req      (push_req)
  );

  mpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  mpc_framer u_framer (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .tx_byte      (tx_byte),
    .frame_last   (out_tlast),
    .track_number (track_number)
  );

endmodule
